[rtl/assert_macros.svh]
// Assertion macros for the checker file of this block.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MAGG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MAGG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/magg_pkg.sv]
// Package of the moving-average gated gain block: field widths, stream
// packing positions, configuration register indexes and gain limits.
// Depends on nothing.
package magg_pkg;

	localparam int PRICE_W    = 32;
	localparam int DAY_W      = 20;
	localparam int GAIN_W     = 40;
	localparam int WLEN_W     = 8;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 1;

	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 64;

	localparam int OUT_DAY_LSB   = 0;
	localparam int OUT_GAIN_LSB  = OUT_DAY_LSB + DAY_W;
	localparam int OUT_GATED_BIT = OUT_GAIN_LSB + GAIN_W;
	localparam int OUT_USED_W    = OUT_GATED_BIT + 1;

	localparam logic signed [GAIN_W-1:0] GAIN_MAX = {1'b0, {(GAIN_W-1){1'b1}}};
	localparam logic signed [GAIN_W-1:0] GAIN_MIN = {1'b1, {(GAIN_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_LENGTH = 1'b0,
		CFG_THRESHOLD     = 1'b1
	} cfg_index_t;

endpackage

[rtl/magg_window_ram.sv]
// Window sample memory: one write port and one registered read port.
// A read of the entry written in the same cycle returns the old contents.
// Depends on nothing.
module magg_window_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7,
	parameter int DW    = 32
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/moving_average_gated_gain.sv]
// Moving-average gated gain. Takes one log-price transaction per clock and
// returns one result per transaction after the first, by way of the stage 1
// and output registers. The window lives in a MAX_WINDOW-entry memory:
// each transaction writes the held sample and reads the sample leaving the
// window, so one memory write and one memory read per item set the rate of
// one item per cycle. Results queue in an output register: while a result
// waits, one more transaction enters the arithmetic stage, and the input
// stalls only once both hold a result. Depends on magg_pkg and magg_window_ram.
module moving_average_gated_gain #(
	parameter int MAX_WINDOW = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// s_tdata: log_price[31:0], day_number[51:32], zero[55:52]
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [magg_pkg::IN_TDATA_W-1:0]      s_tdata,
	// m_tdata: decision_day[19:0], cumulative_gain[59:20], gated_in[60], zero[63:61]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [magg_pkg::OUT_TDATA_W-1:0]     m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [magg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [magg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int PW     = magg_pkg::PRICE_W;
	localparam int DW     = magg_pkg::DAY_W;
	localparam int GW     = magg_pkg::GAIN_W;
	localparam int LW     = magg_pkg::WLEN_W;
	localparam int NW     = $clog2(MAX_WINDOW + 1);
	localparam int AW     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CW     = (NW > LW) ? NW : LW;
	localparam int TOT_W  = PW + NW;
	localparam int PROD_W = PW + 1 + NW;

	// configuration
	logic [LW-1:0]          wlen_q;
	logic signed [PW-1:0]   thr_q;
	logic                   cfg_acc;
	logic                   cfg_wlen_wr;

	// accept-side state
	logic                   have_prev_q;
	logic signed [PW-1:0]   prev_price_q;
	logic [DW-1:0]          prev_day_q;
	logic [AW-1:0]          wp_q;
	logic [NW-1:0]          seen_q;

	// stage 1
	logic                   v_s1;
	logic [DW-1:0]          day_s1;
	logic signed [PW:0]     diff_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PW-1:0]   prev_s1;
	logic                   full_s1;
	logic                   nz_s1;

	// running totals
	logic signed [TOT_W-1:0] total_q;
	logic signed [GW-1:0]    gain_q;

	// output register
	logic                   out_v_q;
	logic [DW-1:0]          out_day_q;
	logic signed [GW-1:0]   out_gain_q;
	logic                   out_gated_q;

	logic                   s_acc;
	logic                   step;
	logic                   adv;
	logic signed [PW-1:0]   in_price;
	logic [DW-1:0]          in_day;
	logic [CW-1:0]          wlen_ext;
	logic [NW-1:0]          n_eff;
	logic                   n_nz;
	logic                   full;
	logic [AW:0]            old_sum;
	logic [AW-1:0]          old_addr;
	logic [AW-1:0]          wp_next;
	logic signed [PW:0]     thr_diff;
	logic signed [PROD_W:0] prod_full;
	logic signed [PW-1:0]   rd_data;
	logic                   gate;
	logic signed [PROD_W-1:0] total_ext;
	logic signed [TOT_W-1:0] total_next;
	logic signed [GW:0]      gain_sum;
	logic signed [GW-1:0]    gain_sat;
	logic signed [GW-1:0]    gain_next;

	assign cfg_ready   = 1'b1;
	assign cfg_acc     = cfg_valid && cfg_ready;
	assign cfg_wlen_wr = cfg_acc
		&& (magg_pkg::cfg_index_t'(cfg_index) == magg_pkg::CFG_WINDOW_LENGTH);

	assign adv      = v_s1 && (!out_v_q || m_tready);
	assign s_tready = !v_s1 || adv;
	assign s_acc    = s_tvalid && s_tready;
	assign step     = s_acc && have_prev_q;

	assign in_price = s_tdata[PW-1:0];
	assign in_day   = s_tdata[PW +: DW];

	// effective window length and slot addresses
	assign wlen_ext = CW'(wlen_q);
	assign n_eff    = (wlen_ext > CW'(MAX_WINDOW)) ? NW'(MAX_WINDOW) : NW'(wlen_ext);
	assign n_nz     = (n_eff != '0);
	assign full     = (seen_q >= n_eff);

	always_comb begin
		old_sum = (AW+1)'(wp_q) + (AW+1)'(MAX_WINDOW) - (AW+1)'(n_eff);
		if (old_sum >= (AW+1)'(MAX_WINDOW)) begin
			old_addr = AW'(old_sum - (AW+1)'(MAX_WINDOW));
		end else begin
			old_addr = AW'(old_sum);
		end
		if ((AW+1)'(wp_q) == (AW+1)'(MAX_WINDOW - 1)) begin
			wp_next = '0;
		end else begin
			wp_next = wp_q + AW'(1);
		end
	end

	assign thr_diff  = {prev_price_q[PW-1], prev_price_q} - {thr_q[PW-1], thr_q};
	assign prod_full = thr_diff * $signed({1'b0, n_eff});

	magg_window_ram #(
		.DEPTH (MAX_WINDOW),
		.AW    (AW),
		.DW    (PW)
	) u_ram (
		.clk     (clk),
		.wr_en   (step && n_nz),
		.wr_addr (wp_q),
		.wr_data (prev_price_q),
		.rd_en   (step && n_nz),
		.rd_addr (old_addr),
		.rd_data (rd_data)
	);

	// stage 1 arithmetic
	always_comb begin
		total_ext  = {{(PROD_W-TOT_W){total_q[TOT_W-1]}}, total_q};
		gate       = !nz_s1 || (full_s1 && (prod_s1 > total_ext));
		total_next = total_q + TOT_W'(prev_s1);
		if (full_s1) begin
			total_next = total_next - TOT_W'(rd_data);
		end
		gain_sum = {gain_q[GW-1], gain_q} + {{(GW-PW){diff_s1[PW]}}, diff_s1};
		if (gain_sum[GW] != gain_sum[GW-1]) begin
			gain_sat = gain_sum[GW] ? magg_pkg::GAIN_MIN : magg_pkg::GAIN_MAX;
		end else begin
			gain_sat = gain_sum[GW-1:0];
		end
		gain_next = gate ? gain_sat : gain_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= '0;
			thr_q  <= '0;
		end else if (cfg_acc) begin
			case (magg_pkg::cfg_index_t'(cfg_index))
				magg_pkg::CFG_WINDOW_LENGTH: wlen_q <= cfg_data[LW-1:0];
				magg_pkg::CFG_THRESHOLD:     thr_q  <= cfg_data[PW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q  <= 1'b0;
			prev_price_q <= '0;
			prev_day_q   <= '0;
			wp_q         <= '0;
			seen_q       <= '0;
			v_s1         <= 1'b0;
			total_q      <= '0;
			gain_q       <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (s_acc) begin
				have_prev_q  <= 1'b1;
				prev_price_q <= in_price;
				prev_day_q   <= in_day;
			end
			if (step && n_nz) begin
				wp_q <= wp_next;
				if (!full) begin
					seen_q <= seen_q + NW'(1);
				end
			end
			if (step) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (adv) begin
				gain_q <= gain_next;
				if (nz_s1) begin
					total_q <= total_next;
				end
			end
			if (cfg_wlen_wr) begin
				wp_q    <= '0;
				seen_q  <= '0;
				total_q <= '0;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			day_s1  <= prev_day_q;
			diff_s1 <= {in_price[PW-1], in_price} - {prev_price_q[PW-1], prev_price_q};
			prod_s1 <= prod_full[PROD_W-1:0];
			prev_s1 <= prev_price_q;
			full_s1 <= full;
			nz_s1   <= n_nz;
		end
		if (adv) begin
			out_day_q   <= day_s1;
			out_gain_q  <= gain_next;
			out_gated_q <= gate;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {
		(magg_pkg::OUT_TDATA_W - magg_pkg::OUT_USED_W)'(0),
		out_gated_q,
		out_gain_q,
		out_day_q
	};

endmodule

[rtl/magg_checker.sv]
// Port-level checker for the moving-average gated gain block, with its bind.
// Depends on magg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module magg_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [magg_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                             cfg_ready
);

	localparam int GW = magg_pkg::GAIN_W;

	logic                 out_acc;
	logic                 seen_out_q;
	logic [GW-1:0]        last_gain_q;
	logic [GW-1:0]        gain;
	logic                 gated;

	assign out_acc = m_tvalid && m_tready;
	assign gain    = m_tdata[magg_pkg::OUT_GAIN_LSB +: GW];
	assign gated   = m_tdata[magg_pkg::OUT_GATED_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_out_q  <= 1'b0;
			last_gain_q <= '0;
		end else if (out_acc) begin
			seen_out_q  <= 1'b1;
			last_gain_q <= gain;
		end
	end

	`MAGG_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output transaction changed while stalled")
	`MAGG_ASSERT_NOW(a_gain_kept, clk, arst_n, out_acc && seen_out_q && !gated, gain == last_gain_q, "gain moved on an ungated result")
	`MAGG_ASSERT_NOW(a_no_bubble, clk, arst_n, !m_tvalid, s_tready, "input stalled with output register empty")
	`MAGG_ASSERT_NOW(a_first_gain, clk, arst_n, out_acc && !seen_out_q && !gated, gain == '0, "first ungated result carries nonzero gain")
	`MAGG_ASSERT_NOW(a_cfg_open, clk, arst_n, 1'b1, cfg_ready, "configuration channel not ready")

endmodule

bind moving_average_gated_gain magg_checker u_magg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tready  (s_tready),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata),
	.cfg_ready (cfg_ready)
);
